/* hdl/kssr_pkg.sv */
// ----------------------------------------------------------------------------
// kssr_pkg: shared types and constants of the key set table
// Opcodes, status codes, sequencer states and the request/response words.
// ----------------------------------------------------------------------------
package kssr_pkg;

   // default sizes handed to the top level
   localparam int KSSR_TABLE_DEPTH = 16;
   localparam int KSSR_KEY_BITS    = 16;

   // fixed field widths of the ports
   localparam int REQ_KEY_BITS   = 16;
   localparam int EVENT_BITS     = 16;
   localparam int KEY_BITS_MAX   = 32;
   localparam int CAP_BITS       = 5;
   localparam int COUNT_OUT_BITS = 5;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;

   // register reset values and the listener event mask (POLLIN | POLLHUP)
   localparam logic [CAP_BITS-1:0]       CAPACITY_RESET     = 5'd16;
   localparam logic [REQ_KEY_BITS-1:0]   LISTENER_KEY_RESET = 16'h0000;
   localparam logic [EVENT_BITS-1:0]     LISTEN_EVENTS      = 16'h0011;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAPACITY     = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LISTENER_KEY = 1'b1;

   typedef enum logic [1:0] {
      OP_INIT   = 2'd0,
      OP_PUSH   = 2'd1,
      OP_POP    = 2'd2,
      OP_REMOVE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_FULL     = 3'd1,
      STATUS_EMPTY    = 3'd2,
      STATUS_NEG_KEY  = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE,
      ST_FETCH_LAST,
      ST_MOVE
   } state_type;

   typedef struct packed {
      opcode_type                     opcode;
      logic signed [REQ_KEY_BITS-1:0] entry_key;
      logic [EVENT_BITS-1:0]          entry_events;
      logic [EVENT_BITS-1:0]          entry_returned;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [COUNT_OUT_BITS-1:0]   count_after;
   } rsp_type;

endpackage

/* hdl/key_set_swap_remove_table.sv */
// ----------------------------------------------------------------------------
// key_set_swap_remove_table: unordered key table with swap-remove
// Holds configuration registers and joins the sequencer to the entry memory.
// ----------------------------------------------------------------------------
// answer: init, push, pop and rejected removes answer in the cycle after start
// and keep busy low, so one may be issued every cycle
// remove: the single key comparator examines each entry in a read and a compare
// state, then the swap passes a fetch-last and a move state; busy falls with
// rsp_valid, so the next word may be taken in the response cycle
// reset: count cleared, capacity 16, listener key 0; no clearing pass
// results are a one-cycle strobe; the receiver cannot stall
module key_set_swap_remove_table
   import kssr_pkg::*;
#(
   parameter int TABLE_DEPTH = KSSR_TABLE_DEPTH,
   parameter int KEY_BITS    = KSSR_KEY_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  req_type                   req_word,
   output logic                      rsp_valid,
   output rsp_type                   rsp_word,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int IW         = $clog2(TABLE_DEPTH);
   localparam int ENTRY_BITS = KEY_BITS + 2 * EVENT_BITS;

   logic [CAP_BITS-1:0]     capacity_ff;
   logic [REQ_KEY_BITS-1:0] listener_key_ff;

   logic [IW-1:0]           mem_rd_addr;
   logic [ENTRY_BITS-1:0]   mem_rd_data;
   logic                    mem_wr_en;
   logic [IW-1:0]           mem_wr_addr;
   logic [ENTRY_BITS-1:0]   mem_wr_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff     <= CAPACITY_RESET;
         listener_key_ff <= LISTENER_KEY_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CAPACITY:     capacity_ff     <= csr_wdata[CAP_BITS-1:0];
            CSR_LISTENER_KEY: listener_key_ff <= csr_wdata[REQ_KEY_BITS-1:0];
            default: begin
               capacity_ff <= capacity_ff;
            end
         endcase
      end
   end

   // sequencer and comparator
   kssr_seq #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req          (req_word),
      .capacity     (capacity_ff),
      .listener_key (listener_key_ff),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp          (rsp_word),
      .mem_rd_addr  (mem_rd_addr),
      .mem_rd_data  (mem_rd_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wr_data  (mem_wr_data)
   );

   // entry memory
   kssr_store #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ENTRY_BITS  (ENTRY_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* hdl/kssr_store.sv */
// ----------------------------------------------------------------------------
// kssr_store: entry memory of the key set table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kssr_store #(
   parameter int TABLE_DEPTH = 16,
   parameter int ENTRY_BITS  = 48
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  logic [ENTRY_BITS-1:0]          wr_data,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output logic [ENTRY_BITS-1:0]          rd_data
);

   logic [ENTRY_BITS-1:0] mem [TABLE_DEPTH];
   logic [ENTRY_BITS-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/kssr_seq.sv */
// ----------------------------------------------------------------------------
// kssr_seq: operation sequencer with the shared key comparator
// Handles init, push and pop at once and walks the table for remove.
// ----------------------------------------------------------------------------
module kssr_seq
   import kssr_pkg::*;
#(
   parameter int TABLE_DEPTH = KSSR_TABLE_DEPTH,
   parameter int KEY_BITS    = KSSR_KEY_BITS
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  req_type                                   req,
   input  logic [CAP_BITS-1:0]                       capacity,
   input  logic [REQ_KEY_BITS-1:0]                   listener_key,
   output logic                                      busy,
   output logic                                      rsp_valid,
   output rsp_type                                   rsp,
   output logic [$clog2(TABLE_DEPTH)-1:0]            mem_rd_addr,
   input  logic [KEY_BITS+2*EVENT_BITS-1:0]          mem_rd_data,
   output logic                                      mem_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]            mem_wr_addr,
   output logic [KEY_BITS+2*EVENT_BITS-1:0]          mem_wr_data
);

   localparam int IW         = $clog2(TABLE_DEPTH);
   localparam int CW         = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_BITS   = (CW > CAP_BITS) ? CW : CAP_BITS;
   localparam int ENTRY_BITS = KEY_BITS + 2 * EVENT_BITS;

   state_type             state_ff, state_in;
   logic [IW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic                  accept;
   logic [CW-1:0]         count_dec;
   logic [IW-1:0]         last_idx;
   logic [CAP_BITS-1:0]   cap_eff;
   logic                  full;
   logic                  match;
   logic                  at_last;
   logic [CMP_BITS-1:0]   count_in_ext;
   logic [CMP_BITS-1:0]   count_ff_ext;

   // sign-extend a 16-bit key, then keep the stored key width
   function automatic logic [KEY_BITS-1:0] key_of(input logic [REQ_KEY_BITS-1:0] raw);
      logic [REQ_KEY_BITS+KEY_BITS_MAX-1:0] ext;
      ext = {{KEY_BITS_MAX{raw[REQ_KEY_BITS-1]}}, raw};
      return ext[KEY_BITS-1:0];
   endfunction

   // shared compare unit and count helpers
   assign accept    = start && (state_ff == ST_IDLE);
   assign count_dec = count_ff - 1'b1;
   assign last_idx  = count_dec[IW-1:0];
   assign at_last   = (idx_ff == last_idx);
   assign match     = (mem_rd_data[ENTRY_BITS-1 -: KEY_BITS] == key_ff);
   assign cap_eff   = (capacity == '0) ? CAP_BITS'(1) : capacity;
   assign full      = (count_ff >= CW'(TABLE_DEPTH)) ||
                      (CMP_BITS'(count_ff) >= CMP_BITS'(cap_eff));
   assign count_in_ext = CMP_BITS'(count_in);
   assign count_ff_ext = CMP_BITS'(count_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req.opcode == OP_REMOVE) && !req.entry_key[REQ_KEY_BITS-1] &&
                (count_ff != '0)) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (match) begin
               state_in = at_last ? ST_IDLE : ST_FETCH_LAST;
            end else begin
               state_in = at_last ? ST_IDLE : ST_READ;
            end
         end
         ST_FETCH_LAST: begin
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      idx_in             = idx_ff;
      count_in           = count_ff;
      key_in             = key_ff;
      rsp_valid_in       = 1'b0;
      rsp_in.status      = STATUS_OK;
      rsp_in.count_after = '0;
      mem_rd_addr        = idx_ff;
      mem_wr_en          = 1'b0;
      mem_wr_addr        = count_ff[IW-1:0];
      mem_wr_data        = {key_of(req.entry_key), req.entry_events, req.entry_returned};
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               unique case (req.opcode)
                  OP_INIT: begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = '0;
                     mem_wr_data = {key_of(listener_key), LISTEN_EVENTS,
                                    {EVENT_BITS{1'b0}}};
                     count_in    = CW'(1);
                  end
                  OP_PUSH: begin
                     if (full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        mem_wr_en = 1'b1;
                        count_in  = CW'(count_ff + 1'b1);
                     end
                  end
                  OP_POP: begin
                     if (count_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        count_in = count_dec;
                     end
                  end
                  OP_REMOVE: begin
                     if (req.entry_key[REQ_KEY_BITS-1]) begin
                        rsp_in.status = STATUS_NEG_KEY;
                     end else if (count_ff == '0) begin
                        rsp_in.status = STATUS_NOT_FOUND;
                     end else begin
                        rsp_valid_in = 1'b0;
                        idx_in       = '0;
                        key_in       = key_of(req.entry_key);
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            mem_rd_addr = idx_ff;
         end
         ST_COMPARE: begin
            if (match) begin
               if (at_last) begin
                  count_in     = count_dec;
                  rsp_valid_in = 1'b1;
               end
            end else if (at_last) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = STATUS_NOT_FOUND;
            end else begin
               idx_in = IW'(idx_ff + 1'b1);
            end
         end
         ST_FETCH_LAST: begin
            mem_rd_addr = last_idx;
         end
         ST_MOVE: begin
            // last entry overwrites the matched slot, then drop the last
            mem_wr_en    = 1'b1;
            mem_wr_addr  = idx_ff;
            mem_wr_data  = mem_rd_data;
            count_in     = count_dec;
            rsp_valid_in = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
      rsp_in.count_after = count_in_ext[COUNT_OUT_BITS-1:0];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      key_ff <= key_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_compare_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMPARE) |-> ($past(state_ff) == ST_READ))
      else $error("compare without a preceding read");

   a_move_below_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE) |-> (idx_ff < last_idx))
      else $error("move targets the last slot");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.count_after == count_ff_ext[COUNT_OUT_BITS-1:0]))
      else $error("reported count differs from table count");
`endif

endmodule

/* dv/kssr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kssr_checker: response checker of the key set table
// Watches the request, response and register ports, keeps its own copy of the
// table keys, count and registers, works out the answer to every accepted
// request word and compares each response word with the oldest answer due.
// ----------------------------------------------------------------------------
module kssr_checker
   import kssr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  req_type                   req_word,
   input  logic                      rsp_valid,
   input  rsp_type                   rsp_word,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output int                        fail_count,
   output int                        outstanding
);

   localparam int SLOTS = KSSR_TABLE_DEPTH;

   // shadow of the table: only keys and the count decide the answers
   logic [REQ_KEY_BITS-1:0] slot_key [SLOTS];
   int unsigned             used_slots;
   logic [CAP_BITS-1:0]     capacity;
   logic [REQ_KEY_BITS-1:0] listener_key;

   rsp_type awaited_answers [$];
   int      mismatches = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // apply one request to the shadow table and return its answer
   function automatic rsp_type table_answer(input req_type w);
      rsp_type     a;
      int unsigned limit;
      int          hit;
      a.status = STATUS_OK;
      hit      = -1;
      // out-of-range capacity is clamped to 1..SLOTS
      if (capacity == 0)
         limit = 1;
      else if (capacity > SLOTS)
         limit = SLOTS;
      else
         limit = 32'(capacity);
      case (w.opcode)
         OP_INIT: begin
            foreach (slot_key[i])
               slot_key[i] = '0;
            slot_key[0] = listener_key;
            used_slots  = 1;
         end
         OP_PUSH: begin
            // a lowered capacity refuses pushes but keeps what is held
            if (used_slots >= limit) begin
               a.status = STATUS_FULL;
            end else begin
               slot_key[used_slots] = w.entry_key;
               used_slots++;
            end
         end
         OP_POP: begin
            if (used_slots == 0) begin
               a.status = STATUS_EMPTY;
            end else begin
               used_slots--;
               slot_key[used_slots] = '0;
            end
         end
         default: begin
            // remove: first match takes the last entry, then the last is dropped
            if (w.entry_key[REQ_KEY_BITS-1]) begin
               a.status = STATUS_NEG_KEY;
            end else begin
               for (int i = 0; i < used_slots; i++)
                  if (hit < 0 && slot_key[i] == w.entry_key)
                     hit = i;
               if (hit < 0) begin
                  a.status = STATUS_NOT_FOUND;
               end else begin
                  slot_key[hit] = slot_key[used_slots-1];
                  used_slots--;
                  slot_key[used_slots] = '0;
               end
            end
         end
      endcase
      a.count_after = used_slots[COUNT_OUT_BITS-1:0];
      return a;
   endfunction

   // responses first: a word accepted at this edge cannot answer at it
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         awaited_answers.delete();
         foreach (slot_key[i])
            slot_key[i] = '0;
         used_slots   = 0;
         capacity     = CAPACITY_RESET;
         listener_key = LISTENER_KEY_RESET;
      end else begin
         if (rsp_valid === 1'b1) begin
            if (awaited_answers.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: status %0d count %0d",
                           rsp_word.status, rsp_word.count_after);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_word.status !== want.status ||
                   rsp_word.count_after !== want.count_after) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("response mismatch: status exp %0d got %0d, count exp %0d got %0d",
                              want.status, rsp_word.status,
                              want.count_after, rsp_word.count_after);
               end
            end
         end
         // register writes are to happen only while the table is idle; no block enforces it
         if (csr_we) begin
            case (csr_index)
               CSR_CAPACITY:     capacity = csr_wdata[CAP_BITS-1:0];
               CSR_LISTENER_KEY: listener_key = csr_wdata;
               default:          ;
            endcase
         end
         if (start && !busy)
            awaited_answers.push_back(table_answer(req_word));
      end
      fail_count  <= mismatches;
      outstanding <= awaited_answers.size();
   end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the key set table
// Drives a directed opening (empty, full, negative key, first match, swap from
// the middle and from the end, clamped and lowered capacity) and then three
// phases of random words with differing sender gaps and register settings.
// A separate checker predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb;
   import kssr_pkg::*;

   localparam int RANDOM_PER_PHASE = 275;
   localparam int SETTLE_CYCLES    = 2 * KSSR_TABLE_DEPTH + 3;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic                      busy;
   req_type                   req_word  = '0;
   logic                      rsp_valid;
   rsp_type                   rsp_word;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;
   int                        fail_count;
   int                        outstanding;

   // keys that keep removes hitting, extremes among them
   logic [REQ_KEY_BITS-1:0] key_pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                             16'h7FFF, 16'h8000, 16'hFFFF, 16'h1234};
   // keys pushed by the directed part; 7FFF repeats the listener key
   logic [REQ_KEY_BITS-1:0] fill_keys [15] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000,
                                               16'h7FFE, 16'h5555, 16'hAAAA, 16'h7FFF,
                                               16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00,
                                               16'h3333, 16'h1234, 16'h4321};

   key_set_swap_remove_table dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   kssr_checker chk (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_word    (rsp_word),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // guard against a hung table
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic req_type make_word(input opcode_type op,
                                         input logic [REQ_KEY_BITS-1:0] key,
                                         input logic [EVENT_BITS-1:0] ev,
                                         input logic [EVENT_BITS-1:0] rv);
      req_type w;
      w.opcode         = op;
      w.entry_key      = key;
      w.entry_events   = ev;
      w.entry_returned = rv;
      return w;
   endfunction

   // random word: mostly pool keys, pushes and removes weighted up
   function automatic req_type random_word();
      opcode_type              op;
      logic [REQ_KEY_BITS-1:0] key;
      int                      pick;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         op = OP_INIT;
      else if (pick < 46)
         op = OP_PUSH;
      else if (pick < 64)
         op = OP_POP;
      else
         op = OP_REMOVE;
      if ($urandom_range(0, 3) == 0)
         key = REQ_KEY_BITS'($urandom);
      else
         key = key_pool[3'($urandom_range(0, 7))];
      return make_word(op, key, EVENT_BITS'($urandom), EVENT_BITS'($urandom));
   endfunction

   // hold the word until an edge with busy low takes it
   task automatic issue_word(input req_type w);
      start    <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // stop sending and wait until every answer is in and the table is idle
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (busy || outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic random_phase(input int idle_pct);
      repeat (RANDOM_PER_PHASE) begin
         issue_word(random_word());
         if ($urandom_range(0, 99) < idle_pct)
            idle_cycles($urandom_range(1, 4));
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero capacity acts as one; most negative listener key
      write_reg(CSR_CAPACITY, 16'd0);
      write_reg(CSR_LISTENER_KEY, 16'h8000);
      issue_word(make_word(OP_POP, 16'h0000, 16'h0000, 16'h0000));
      issue_word(make_word(OP_REMOVE, 16'h0005, 16'h0000, 16'h0000));
      issue_word(make_word(OP_REMOVE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      issue_word(make_word(OP_INIT, 16'h0000, 16'h0000, 16'h0000));
      issue_word(make_word(OP_PUSH, 16'h0007, 16'hFFFF, 16'h0000));
      drain();

      // capacity above the depth is clamped; fill the whole table
      write_reg(CSR_CAPACITY, 16'd31);
      write_reg(CSR_LISTENER_KEY, 16'h7FFF);
      issue_word(make_word(OP_INIT, 16'h0000, 16'h0000, 16'h0000));
      for (int i = 0; i < 15; i++)
         issue_word(make_word(OP_PUSH, fill_keys[i],
                              i[0] ? 16'hFFFF : 16'h0000, i[0] ? 16'h0000 : 16'hFFFF));
      issue_word(make_word(OP_PUSH, 16'h0042, 16'h0000, 16'h0000));
      // first match is slot zero; then the entry that is last; then a middle one
      issue_word(make_word(OP_REMOVE, 16'h7FFF, 16'h0000, 16'h0000));
      issue_word(make_word(OP_REMOVE, fill_keys[13], 16'h0000, 16'h0000));
      issue_word(make_word(OP_REMOVE, fill_keys[5], 16'h0000, 16'h0000));
      issue_word(make_word(OP_REMOVE, 16'h8000, 16'h0000, 16'h0000));
      drain();

      // capacity lowered below the count: full, but nothing is dropped
      write_reg(CSR_CAPACITY, 16'd2);
      issue_word(make_word(OP_PUSH, 16'h0009, 16'h1111, 16'h2222));
      issue_word(make_word(OP_POP, 16'h0000, 16'h0000, 16'h0000));
      issue_word(make_word(OP_REMOVE, fill_keys[0], 16'h0000, 16'h0000));
      drain();

      write_reg(CSR_CAPACITY, 16'd16);
      write_reg(CSR_LISTENER_KEY, 16'h0003);
      random_phase(8);

      write_reg(CSR_CAPACITY, CSR_DATA_BITS'($urandom_range(1, 8)));
      write_reg(CSR_LISTENER_KEY, CSR_DATA_BITS'($urandom));
      random_phase(46);

      write_reg(CSR_CAPACITY, 16'd31);
      write_reg(CSR_LISTENER_KEY, 16'h0000);
      random_phase(0);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
